// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define AST_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define AST_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/itic_pkg.sv =====
package itic_pkg;

  // Counter layout
  localparam int NUM_CATS        = 22;
  localparam int CAT_W           = 5;
  localparam logic [CAT_W-1:0] LAST_CAT = 5'd21;
  localparam int C_TOTAL         = 0;
  localparam int C_DIR           = 1;
  localparam int C_TCP           = 4;
  localparam int C_UDP           = 8;
  localparam int C_LOCAL         = 12;
  localparam int C_EXT           = 16;

  localparam int COUNT_WIDTH_DEF = 32;

  // Header decode
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
  localparam logic [7:0] PROTO_TCP     = 8'd6;
  localparam logic [7:0] PROTO_UDP     = 8'd17;

  // Direction offsets within a category group
  localparam logic [1:0] DIR_IN    = 2'd0;
  localparam logic [1:0] DIR_OUT   = 2'd1;
  localparam logic [1:0] DIR_CROSS = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOST_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_NUMBER = 1'b1;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef logic [NUM_CATS-1:0] cat_mask_t;

  // One queued word: a tick, or a classified packet with its hit mask
  typedef struct packed {
    logic        is_tick;
    cat_mask_t   mask;
    logic [15:0] len;
    logic [31:0] stamp;
  } q_word_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  // Build the set of categories one packet advances
  function automatic cat_mask_t cat_mask(input logic [1:0] dir, input logic is_local,
                                         input logic is_tcp, input logic is_udp);
    cat_mask_t m;
    m = '0;
    m[C_TOTAL] = 1'b1;
    m[C_DIR + int'(dir)] = 1'b1;
    if (is_local) begin
      m[C_LOCAL] = 1'b1;
      m[C_LOCAL + 1 + int'(dir)] = 1'b1;
    end else begin
      m[C_EXT] = 1'b1;
      m[C_EXT + 1 + int'(dir)] = 1'b1;
    end
    if (is_tcp) begin
      m[C_TCP] = 1'b1;
      m[C_TCP + 1 + int'(dir)] = 1'b1;
    end else if (is_udp) begin
      m[C_UDP] = 1'b1;
      m[C_UDP + 1 + int'(dir)] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== rtl/itic_in_if.sv =====
interface itic_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] time_sec;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [3:0]  header_words;
  logic [7:0]  protocol;
  logic [15:0] total_len;

  modport source (output valid, cmd, time_sec, src_addr, dst_addr, header_words,
                  protocol, total_len, input ready);
  modport sink (input valid, cmd, time_sec, src_addr, dst_addr, header_words,
                protocol, total_len, output ready);
endinterface

// ===== rtl/itic_out_if.sv =====
interface itic_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  category;
  logic [31:0] packet_count;
  logic [31:0] byte_count;
  logic [31:0] interval_time;
  logic        last;

  modport source (output valid, category, packet_count, byte_count, interval_time, last,
                  input ready);
  modport sink (input valid, category, packet_count, byte_count, interval_time, last,
                output ready);
endinterface

// ===== rtl/itic_front.sv =====
module itic_front (
  input  logic                               clk,
  input  logic                               rst_n,
  itic_in_if.sink                            in_if,
  input  logic                               cfg_we,
  input  logic [itic_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_wdata,
  input  itic_pkg::q_stat_t                  q_stat,
  output logic                               push,
  output itic_pkg::q_word_t                  push_word
);

  logic [31:0] host_addr_r;
  logic [31:0] net_number_r;
  logic [1:0]  dir;
  logic        is_local;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_addr_r  <= '0;
      net_number_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        itic_pkg::CFG_HOST_ADDR:  host_addr_r  <= cfg_wdata;
        itic_pkg::CFG_NET_NUMBER: net_number_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify direction, source first
  always_comb begin
    if (in_if.src_addr == host_addr_r) begin
      dir = itic_pkg::DIR_OUT;
    end else if (in_if.dst_addr == host_addr_r) begin
      dir = itic_pkg::DIR_IN;
    end else begin
      dir = itic_pkg::DIR_CROSS;
    end
  end

  assign is_local = ((net_number_r & in_if.src_addr) == net_number_r) &&
                    ((net_number_r & in_if.dst_addr) == net_number_r);

  // Accept while the queue has room; drop short headers here
  assign in_if.ready = !q_stat.full;
  assign push = in_if.valid && !q_stat.full &&
                (in_if.cmd || (in_if.header_words >= itic_pkg::MIN_HDR_WORDS));

  assign push_word.is_tick = in_if.cmd;
  assign push_word.mask    = itic_pkg::cat_mask(dir, is_local,
                                                in_if.protocol == itic_pkg::PROTO_TCP,
                                                in_if.protocol == itic_pkg::PROTO_UDP);
  assign push_word.len     = in_if.total_len;
  assign push_word.stamp   = in_if.time_sec;

endmodule

// ===== rtl/itic_fifo.sv =====
module itic_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  itic_pkg::q_word_t wdata,
  input  logic              pop,
  output itic_pkg::q_word_t rdata,
  output itic_pkg::q_stat_t stat
);

  itic_pkg::q_word_t                mem_r [itic_pkg::QDEPTH];
  logic [itic_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [itic_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [itic_pkg::QPTR_W:0]        count_r;

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == (itic_pkg::QPTR_W + 1)'(itic_pkg::QDEPTH));

endmodule

// ===== rtl/itic_back.sv =====
module itic_back #(
  parameter int COUNT_WIDTH = itic_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  itic_pkg::q_stat_t q_stat,
  input  itic_pkg::q_word_t q_word,
  output logic              pop,
  itic_out_if.source        out_if
);

  typedef enum logic {ST_RUN, ST_READ} st_t;

  st_t                          state_r;
  logic [itic_pkg::CAT_W-1:0]   idx_r;
  logic [31:0]                  stamp_r;
  logic [COUNT_WIDTH-1:0]       pkt_r   [itic_pkg::NUM_CATS];
  logic [COUNT_WIDTH-1:0]       byte_r  [itic_pkg::NUM_CATS];
  logic [COUNT_WIDTH-1:0]       pkt_nxt [itic_pkg::NUM_CATS];
  logic [COUNT_WIDTH-1:0]       byte_nxt[itic_pkg::NUM_CATS];
  logic [COUNT_WIDTH-1:0]       len_ext;

  logic                         out_valid_r;
  logic [itic_pkg::CAT_W-1:0]   out_cat_r;
  logic [31:0]                  out_pkt_r;
  logic [31:0]                  out_byte_r;
  logic [31:0]                  out_time_r;
  logic                         out_last_r;

  logic out_free;
  logic upd;
  logic clr;
  logic start;

  assign out_free = !out_valid_r || out_if.ready;
  assign len_ext  = COUNT_WIDTH'(q_word.len);

  // Decide what the head word does this cycle
  always_comb begin
    pop   = 1'b0;
    upd   = 1'b0;
    clr   = 1'b0;
    start = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (q_stat.valid) begin
          if (!q_word.is_tick) begin
            upd = 1'b1;
            pop = 1'b1;
          end else if (stamp_r == '0) begin
            pop = 1'b1;
          end else begin
            start = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          clr = 1'b1;
          pop = (idx_r == itic_pkg::LAST_CAT);
        end
      end
      default: ;
    endcase
  end

  // Advance hit counters, zero each one as it is read out
  always_comb begin
    for (int k = 0; k < itic_pkg::NUM_CATS; k++) begin
      pkt_nxt[k]  = pkt_r[k];
      byte_nxt[k] = byte_r[k];
      if (clr && (idx_r == itic_pkg::CAT_W'(k))) begin
        pkt_nxt[k]  = '0;
        byte_nxt[k] = '0;
      end else if (upd && q_word.mask[k]) begin
        pkt_nxt[k]  = pkt_r[k] + 1'b1;
        byte_nxt[k] = byte_r[k] + len_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < itic_pkg::NUM_CATS; k++) begin
      if (!rst_n) begin
        pkt_r[k]  <= '0;
        byte_r[k] <= '0;
      end else begin
        pkt_r[k]  <= pkt_nxt[k];
        byte_r[k] <= byte_nxt[k];
      end
    end
  end

  // Sequence state, interval stamp and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      idx_r       <= '0;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise valid on a load, drop it once the word is taken
      if (clr) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (upd) stamp_r <= q_word.stamp;
      case (state_r)
        ST_RUN: begin
          if (start) begin
            state_r <= ST_READ;
            idx_r   <= '0;
          end
        end
        ST_READ: begin
          if (clr) begin
            out_cat_r   <= idx_r;
            out_pkt_r   <= 32'(pkt_r[idx_r]);
            out_byte_r  <= 32'(byte_r[idx_r]);
            out_time_r  <= stamp_r;
            out_last_r  <= (idx_r == itic_pkg::LAST_CAT);
            if (idx_r == itic_pkg::LAST_CAT) begin
              state_r <= ST_RUN;
              stamp_r <= '0;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.category      = out_cat_r;
  assign out_if.packet_count  = out_pkt_r;
  assign out_if.byte_count    = out_byte_r;
  assign out_if.interval_time = out_time_r;
  assign out_if.last          = out_last_r;

endmodule

// ===== rtl/ip_traffic_interval_counters.sv =====
// Packets: one word per cycle while the queue has room; each is queued, then counted
// from the queue head. Ticks: with a nonzero interval time, 22 words leave the output
// register at one per cycle while they are taken, once the tick reaches the queue head.
// Input stalls while the four-word queue is full; it fills only during a readout.
// Reset (rst_n low, synchronous) clears counters, interval time, registers and queue.
`include "assert_macros.svh"

module ip_traffic_interval_counters #(
  parameter int COUNT_WIDTH = itic_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  itic_in_if.sink                        in_if,
  itic_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [itic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  itic_pkg::q_stat_t q_stat;
  itic_pkg::q_word_t push_word;
  itic_pkg::q_word_t head_word;
  logic              push;
  logic              pop;

  itic_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_word (push_word)
  );

  itic_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_word),
    .pop   (pop),
    .rdata (head_word),
    .stat  (q_stat)
  );

  itic_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_word (head_word),
    .pop    (pop),
    .out_if (out_if)
  );

  `AST_IMP(a_push_room, clk, rst_n, push, !q_stat.full, "push into a full queue")
  `AST_IMP(a_pop_valid, clk, rst_n, pop, q_stat.valid, "pop from an empty queue")
  `AST_IMP(a_last_cat, clk, rst_n, out_if.valid && out_if.last, out_if.category == itic_pkg::LAST_CAT, "last flag off the final category")
  `AST_NEXT(a_last_ends, clk, rst_n, out_if.valid && out_if.ready && out_if.last, !out_if.valid || out_if.category == '0, "readout continues past its last word")

endmodule
